// File: hw/rtl/page_frame_free_list_allocator_unit_macros.svh
// Assertion macros used by the allocator port checker.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: hw/rtl/pfa_pkg.sv
// Shared types and constants of the page-frame allocator.
package pfa_pkg;

  localparam int DEF_POOL_PAGES = 128;
  localparam int COUNT_W        = 8;
  localparam int PAGE_OUT_W     = 7;
  localparam int ADDR_W         = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int PAGE_SHIFT     = 12;

  localparam logic [ADDR_W-1:0] PAGE_ALIGN_MASK = 32'hFFFF_F000;
  localparam logic [ADDR_W-1:0] POOL_OFFSET     = 32'h0000_1000;

  // Register index taken from paddr[2].
  localparam logic [0:0] REG_KERNEL_END = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [COUNT_W-1:0]      page_count;
    logic [PAGE_OUT_W-1:0]   chain_head;
    logic                    chain_absent;
  } cmd_t;

  typedef struct packed {
    logic                  granted;
    logic [PAGE_OUT_W-1:0] first_page;
    logic [ADDR_W-1:0]     first_address;
  } result_t;

endpackage

// File: hw/rtl/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pfa_ctrl.sv
// Sequencer that walks the link memory for allocate, free and pool rebuild.
module pfa_ctrl import pfa_pkg::*; #(
  parameter int POOL_PAGES = DEF_POOL_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cmd_t              cmd,
  input  logic [ADDR_W-1:0] base,
  output logic              busy,
  output logic              res_valid,
  output result_t           res
);

  localparam int IW = $clog2(POOL_PAGES);
  localparam int LW = $clog2(POOL_PAGES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_PAGES);

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_ALLOC, ST_FREE} state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      sweep_r, sweep_nxt;
  logic               reinit_r, reinit_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [COUNT_W-1:0] got_r, got_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [LW-1:0]      steps_r, steps_nxt;
  logic [LW-1:0]      free_head_r, free_head_nxt;
  logic               res_valid_r, res_valid_nxt;
  result_t            res_r, res_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  logic              link_null;
  logic              head_null;
  logic              chain_out;
  logic [ADDR_W-1:0] grant_addr;

  pfa_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign link_null  = ram_rdata >= NULL_LINK;
  assign head_null  = free_head_r >= NULL_LINK;
  assign chain_out  = 32'(cmd.chain_head) >= 32'(POOL_PAGES);
  assign grant_addr = base + (ADDR_W'(head_r) << PAGE_SHIFT);

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    reinit_nxt    = reinit_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    got_nxt       = got_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    free_head_nxt = free_head_r;
    res_valid_nxt = 1'b0;
    res_nxt       = '0;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = NULL_LINK;
    ram_raddr     = IW'(free_head_r);

    unique case (state_r)
      ST_INIT: begin
        // Chain page i to i+1; the last page links to null.
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = LW'(sweep_r) + LW'(1);
        sweep_nxt = sweep_r + IW'(1);
        if (sweep_r == IW'(POOL_PAGES - 1)) begin
          state_nxt     = ST_IDLE;
          free_head_nxt = '0;
          res_valid_nxt = reinit_r;
          reinit_nxt    = 1'b0;
        end
      end
      ST_IDLE: begin
        if (cmd.opcode == OP_FREE) begin
          ram_raddr = IW'(cmd.chain_head);
        end
        if (start) begin
          unique case (cmd.opcode)
            OP_ALLOC: begin
              if (cmd.page_count == '0 || head_null) begin
                res_valid_nxt = 1'b1;
              end else begin
                head_nxt  = IW'(free_head_r);
                cur_nxt   = IW'(free_head_r);
                got_nxt   = COUNT_W'(1);
                count_nxt = cmd.page_count;
                state_nxt = ST_ALLOC;
              end
            end
            OP_FREE: begin
              if (cmd.chain_absent || chain_out) begin
                res_valid_nxt = 1'b1;
              end else begin
                head_nxt  = IW'(cmd.chain_head);
                cur_nxt   = IW'(cmd.chain_head);
                steps_nxt = '0;
                state_nxt = ST_FREE;
              end
            end
            OP_REINIT: begin
              sweep_nxt  = '0;
              reinit_nxt = 1'b1;
              state_nxt  = ST_INIT;
            end
            OP_NOP: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        ram_raddr = IW'(ram_rdata);
        if (got_r < count_r && !link_null) begin
          cur_nxt = IW'(ram_rdata);
          got_nxt = got_r + COUNT_W'(1);
        end else begin
          // Cut the chain after the current page; the rest stays free.
          free_head_nxt         = ram_rdata;
          ram_we                = 1'b1;
          ram_waddr             = cur_r;
          ram_wdata             = NULL_LINK;
          res_valid_nxt         = 1'b1;
          res_nxt.granted       = 1'b1;
          res_nxt.first_page    = PAGE_OUT_W'(head_r);
          res_nxt.first_address = grant_addr;
          state_nxt             = ST_IDLE;
        end
      end
      ST_FREE: begin
        ram_raddr = IW'(ram_rdata);
        if (!link_null) begin
          // Drop the request when no tail shows up within the pool size.
          if (steps_r == LW'(POOL_PAGES)) begin
            res_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cur_nxt   = IW'(ram_rdata);
            steps_nxt = steps_r + LW'(1);
          end
        end else begin
          ram_we        = 1'b1;
          ram_waddr     = cur_r;
          ram_wdata     = free_head_r;
          free_head_nxt = LW'(head_r);
          res_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      reinit_r    <= 1'b0;
      free_head_r <= '0;
      res_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      reinit_r    <= reinit_nxt;
      free_head_r <= free_head_nxt;
      res_valid_r <= res_valid_nxt;
      res_r       <= res_nxt;
    end
    head_r  <= head_nxt;
    cur_r   <= cur_nxt;
    got_r   <= got_nxt;
    count_r <= count_nxt;
    steps_r <= steps_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: hw/rtl/page_frame_free_list_allocator_unit.sv
// Top level of the page-frame allocator: register port and sequencer.
//
// A command word is taken at a rising edge with start high and busy low:
// in_opcode selects allocate, free chain, rebuild pool, or no operation.
// Every command gives exactly one result word, shown for one cycle with
// out_valid high; the receiver cannot stall it. out_granted, out_first_page
// and out_first_address are zero for anything but a granted allocate.
// Links are kept in a one-read, one-write memory and are followed one per
// cycle, so that memory's read port sets the pace: an allocate walks the
// pages it grants, a free walks the chain to its tail (and drops a chain
// with no tail within the pool size), and a rebuild writes every link.
// The result strobes in the cycle busy drops. Commands that need no walk
// (no chain, empty list, zero count, no operation) answer in the cycle
// after start while busy stays low. After reset the block rebuilds the
// pool with busy high; register writes are taken meanwhile.
// kernel_end sits at byte address 0 of the APB port and resets to 0.
module page_frame_free_list_allocator_unit import pfa_pkg::*; #(
  parameter int POOL_PAGES = DEF_POOL_PAGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [COUNT_W-1:0]    in_page_count,
  input  logic [PAGE_OUT_W-1:0] in_chain_head,
  input  logic                  in_chain_absent,
  output logic                  out_valid,
  output logic                  out_granted,
  output logic [PAGE_OUT_W-1:0] out_first_page,
  output logic [ADDR_W-1:0]     out_first_address,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [ADDR_W-1:0] kernel_end_r, kernel_end_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              reg_hit;
  logic              cfg_wr;
  cmd_t              cmd;
  result_t           res;

  assign reg_hit = paddr[CFG_ADDR_W-1:2] == REG_KERNEL_END;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? kernel_end_r : '0;

  // Precompute the pool base so a grant needs only one add.
  always_comb begin
    kernel_end_nxt = kernel_end_r;
    base_nxt       = base_r;
    if (cfg_wr && reg_hit) begin
      kernel_end_nxt = pwdata;
      base_nxt       = (pwdata & PAGE_ALIGN_MASK) + POOL_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_end_r <= '0;
      base_r       <= POOL_OFFSET;
    end else begin
      kernel_end_r <= kernel_end_nxt;
      base_r       <= base_nxt;
    end
  end

  assign cmd.opcode       = opcode_t'(in_opcode);
  assign cmd.page_count   = in_page_count;
  assign cmd.chain_head   = in_chain_head;
  assign cmd.chain_absent = in_chain_absent;

  pfa_ctrl #(
    .POOL_PAGES (POOL_PAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .base      (base_r),
    .busy      (busy),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_granted       = res.granted;
  assign out_first_page    = res.first_page;
  assign out_first_address = res.first_address;

endmodule

// File: hw/rtl/pfa_chk.sv
// Port-level checker for the allocator, bound to the top level.
`include "page_frame_free_list_allocator_unit_macros.svh"

module pfa_chk import pfa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              out_granted,
  input logic [ADDR_W-1:0] out_first_address
);

  // A taken command either starts a walk or answers at once.
  `PFA_ASSERT_NEXT(a_cmd_progress, start && !busy, busy || out_valid)
  // Results show only once the sequencer is back at rest.
  `PFA_ASSERT_NOW(a_res_when_idle, out_valid, !busy)
  `PFA_ASSERT_NOW(a_grant_strobed, out_granted, out_valid)
  // Page addresses stay on 4 KiB boundaries.
  `PFA_ASSERT_NOW(a_grant_aligned, out_granted, out_first_address[11:0] == 12'h000)

endmodule

bind page_frame_free_list_allocator_unit pfa_chk u_pfa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_granted       (out_granted),
  .out_first_address (out_first_address)
);

// File: sim/page_frame_free_list_allocator_unit_checker.sv
// Checker for the page-frame allocator: tracks the free list and compares every result word.
`timescale 1ns / 1ps

module page_frame_free_list_allocator_unit_checker import pfa_pkg::*; #(
  parameter int POOL_PAGES = DEF_POOL_PAGES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [COUNT_W-1:0]    in_page_count,
  input  logic [PAGE_OUT_W-1:0] in_chain_head,
  input  logic                  in_chain_absent,
  input  logic                  out_valid,
  input  logic                  out_granted,
  input  logic [PAGE_OUT_W-1:0] out_first_page,
  input  logic [ADDR_W-1:0]     out_first_address,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_total,
  output int                    words_pending
);

  localparam logic [7:0] NULL_LINK = 8'(POOL_PAGES);

  logic [7:0]        link_mem [POOL_PAGES];
  logic [7:0]        list_head;
  logic [ADDR_W-1:0] kernel_end;
  result_t           grant_fifo [$];
  int                fails = 0;

  function automatic void rebuild_pool();
    for (int i = 0; i < POOL_PAGES; i++) link_mem[i] = 8'(i + 1);
    list_head = 8'd0;
  endfunction

  // Apply one command to the tracked list and return the word it must produce.
  function automatic result_t predict_word(opcode_t op, logic [COUNT_W-1:0] cnt,
                                           logic [PAGE_OUT_W-1:0] chead, logic absent);
    result_t w;
    int      cur;
    int      got;
    int      tail;
    int      steps;
    bit      has_tail;
    w = '0;
    case (op)
      OP_ALLOC: begin
        if (cnt != 0 && list_head < NULL_LINK) begin
          cur = list_head;
          got = 1;
          while (got < cnt && link_mem[cur] < NULL_LINK) begin
            cur = link_mem[cur];
            got++;
          end
          w.granted       = 1'b1;
          w.first_page    = list_head[PAGE_OUT_W-1:0];
          w.first_address = (kernel_end & PAGE_ALIGN_MASK) + POOL_OFFSET +
                            (ADDR_W'(list_head) << PAGE_SHIFT);
          list_head     = link_mem[cur];
          link_mem[cur] = NULL_LINK;
        end
      end
      OP_FREE: begin
        if (!absent && chead < POOL_PAGES) begin
          tail     = chead;
          steps    = 0;
          has_tail = 1'b1;
          // a chain with no tail inside one pool's worth of steps is cyclic: drop it
          while (has_tail && link_mem[tail] < NULL_LINK) begin
            if (steps >= POOL_PAGES) begin
              has_tail = 1'b0;
            end else begin
              tail = link_mem[tail];
              steps++;
            end
          end
          if (has_tail) begin
            link_mem[tail] = list_head;
            list_head      = 8'(chead);
          end
        end
      end
      OP_REINIT: rebuild_pool();
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      rebuild_pool();
      kernel_end = '0;
      grant_fifo.delete();
    end else begin
      // a word on the outputs always belongs to an earlier command: check before predicting
      if (out_valid) begin
        if (grant_fifo.size() == 0) begin
          $error("result word with no command outstanding");
          fails++;
        end else begin
          want = grant_fifo.pop_front();
          if (out_granted !== want.granted) begin
            $error("granted mismatch: expected %0d, actual %0d", want.granted, out_granted);
            fails++;
          end
          if (out_first_page !== want.first_page) begin
            $error("first_page mismatch: expected %0d, actual %0d",
                   want.first_page, out_first_page);
            fails++;
          end
          if (out_first_address !== want.first_address) begin
            $error("first_address mismatch: expected 0x%08h, actual 0x%08h",
                   want.first_address, out_first_address);
            fails++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_KERNEL_END)
        kernel_end = pwdata;
      if (start && !busy)
        grant_fifo.push_back(predict_word(opcode_t'(in_opcode), in_page_count,
                                          in_chain_head, in_chain_absent));
    end
    words_pending <= grant_fifo.size();
    fail_total    <= fails;
  end

endmodule

// File: sim/page_frame_free_list_allocator_unit_tb.sv
// Testbench top for the page-frame allocator: clock, reset, commands and verdict.
`timescale 1ns / 1ps

module page_frame_free_list_allocator_unit_tb import pfa_pkg::*;;

  localparam int POOL_PAGES   = DEF_POOL_PAGES;
  localparam int PHASE_ITEMS  = 390;
  localparam int QUIET_LIMIT  = 4000;
  localparam logic [CFG_ADDR_W-1:0] KERNEL_END_ADDR = {REG_KERNEL_END, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_opcode;
  logic [COUNT_W-1:0]    in_page_count;
  logic [PAGE_OUT_W-1:0] in_chain_head;
  logic                  in_chain_absent;
  logic                  out_valid;
  logic                  out_granted;
  logic [PAGE_OUT_W-1:0] out_first_page;
  logic [ADDR_W-1:0]     out_first_address;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_total;
  int                    words_pending;

  logic [PAGE_OUT_W-1:0] live_heads [$];
  bit                    no_idle;
  int                    quiet_cycles;

  always #5 clk = ~clk;

  page_frame_free_list_allocator_unit #(.POOL_PAGES(POOL_PAGES)) dut (.*);

  page_frame_free_list_allocator_unit_checker #(.POOL_PAGES(POOL_PAGES)) checker_i (.*);

  // Cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** page_frame_free_list_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Advance one edge; track heads handed out so later frees return real chains.
  task automatic step_clk(output bit took);
    @(posedge clk);
    took = start && !busy;
    if (took && opcode_t'(in_opcode) == OP_REINIT)
      live_heads.delete();
    else if (out_valid && out_granted)
      live_heads.push_back(out_first_page);
  endtask

  task automatic issue(opcode_t op, logic [COUNT_W-1:0] cnt, logic [PAGE_OUT_W-1:0] head,
                       logic absent);
    bit took;
    while (!no_idle && $urandom_range(99) < 27) begin
      start <= 1'b0;
      step_clk(took);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_page_count   <= cnt;
    in_chain_head   <= head;
    in_chain_absent <= absent;
    do step_clk(took); while (!took);
  endtask

  // Hold off commands until every result word is back.
  task automatic drain();
    bit took;
    start <= 1'b0;
    step_clk(took);
    while (words_pending != 0) step_clk(took);
  endtask

  task automatic write_kernel_end(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KERNEL_END_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_cmd();
    int                    pick;
    int                    slot;
    logic [PAGE_OUT_W-1:0] head;
    logic [COUNT_W-1:0]    cnt;
    pick = $urandom_range(99);
    head = PAGE_OUT_W'($urandom);
    cnt  = COUNT_W'($urandom_range(128));
    if (pick < 3) begin
      issue(OP_REINIT, cnt, head, 1'($urandom));
    end else if (pick < 5) begin
      issue(OP_NOP, cnt, head, 1'($urandom));
    end else if (pick < 7) begin
      // stray free: may hit the free list itself or a page already freed
      issue(OP_FREE, cnt, head, 1'($urandom));
    end else if (pick < 10) begin
      issue(OP_ALLOC, cnt, head, 1'($urandom));
    end else if (live_heads.size() != 0 && (live_heads.size() > 6 || $urandom_range(1))) begin
      slot = $urandom_range(live_heads.size() - 1);
      head = live_heads[slot];
      live_heads.delete(slot);
      issue(OP_FREE, cnt, head, 1'b0);
    end else begin
      if ($urandom_range(19) == 0) cnt = COUNT_W'($urandom_range(128, 7));
      else cnt = COUNT_W'($urandom_range(6, 1));
      issue(OP_ALLOC, cnt, head, 1'($urandom));
    end
  endtask

  task automatic run_phase(logic [31:0] kend, bit calm_start);
    drain();
    write_kernel_end(kend);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      no_idle = calm_start && n < PHASE_ITEMS / 3;
      if ($urandom_range(199) == 0) drain();
      random_cmd();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= OP_NOP;
    in_page_count   <= '0;
    in_chain_head   <= '0;
    in_chain_absent <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    no_idle          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: kernel_end still at its reset value
    issue(OP_ALLOC,  8'd0,   7'd0,   1'b0);   // zero count grants nothing
    issue(OP_ALLOC,  8'd1,   7'd0,   1'b0);
    issue(OP_ALLOC,  8'd128, 7'd127, 1'b0);   // takes the rest of the pool
    issue(OP_ALLOC,  8'd5,   7'd0,   1'b0);   // empty list
    issue(OP_FREE,   8'd0,   7'd0,   1'b1);   // no chain: ignored
    issue(OP_FREE,   8'd0,   7'd0,   1'b0);   // into an empty list
    issue(OP_FREE,   8'd0,   7'd1,   1'b0);
    issue(OP_ALLOC,  8'd128, 7'd0,   1'b0);
    issue(OP_NOP,    8'd128, 7'd127, 1'b1);
    issue(OP_REINIT, 8'd0,   7'd0,   1'b0);
    issue(OP_FREE,   8'd0,   7'd127, 1'b0);   // tail of the free list: list closes on itself
    issue(OP_FREE,   8'd0,   7'd5,   1'b0);   // cyclic chain: dropped
    issue(OP_ALLOC,  8'd128, 7'd0,   1'b0);
    issue(OP_REINIT, 8'd0,   7'd0,   1'b0);
    issue(OP_ALLOC,  8'd3,   7'd0,   1'b0);
    issue(OP_FREE,   8'd0,   7'd0,   1'b0);
    issue(OP_FREE,   8'd0,   7'd0,   1'b0);   // same chain twice
    issue(OP_ALLOC,  8'd127, 7'd85,  1'b1);
    issue(OP_NOP,    8'd0,   7'd0,   1'b0);
    issue(OP_REINIT, 8'd85,  7'd42,  1'b1);
    issue(OP_ALLOC,  8'd85,  7'd42,  1'b0);
    issue(OP_ALLOC,  8'd42,  7'd85,  1'b1);

    run_phase(32'hFFFF_FFFF, 1'b0);
    run_phase(32'h0000_0000, 1'b1);
    run_phase($urandom, 1'b0);
    run_phase(32'hFFF8_0ABC, 1'b0);
    run_phase($urandom, 1'b0);

    drain();
    repeat (POOL_PAGES + 8) @(posedge clk);
    if (fail_total == 0 && words_pending == 0) begin
      $display("** page_frame_free_list_allocator_unit: PASSED **");
    end else begin
      $display("** page_frame_free_list_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
